FILE: rtl/core/dtre_pkg.sv
`default_nettype none
package dtre_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int TILE       = 64;
  localparam int TILE_SHIFT = $clog2(TILE);

  localparam int GRID_X = (MAX_WIDTH + TILE - 1) / TILE;
  localparam int GRID_Y = (MAX_HEIGHT + TILE - 1) / TILE;
  localparam int GRID_N = GRID_X * GRID_Y;

  localparam int DIM_W   = 12;                               // register width of a dimension
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int STORE_N = MAX_WIDTH * MAX_HEIGHT;
  localparam int TIDX_W  = $clog2(GRID_N);
  localparam int COUNT_W = $clog2(GRID_N + 1);
  localparam int TX_W    = $clog2(GRID_X + 1);
  localparam int TY_W    = $clog2(GRID_Y + 1);
  localparam int TC_W    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int TR_W    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int TSZ_W   = TILE_SHIFT + 1;                   // holds 1..TILE
  localparam int PIX_W   = 16;

  localparam int PADDR_W = 4;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(1080);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_PULL  = 1'b1;

  localparam logic FMT_BGRA32 = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  typedef logic [DIM_W-1:0] dim_t;

  function automatic dim_t sat_dim(input dim_t v, input dim_t hi);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dtre_ram.sv
`default_nettype none
module dtre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/dirty_tile_rgb565_encoder.sv
`default_nettype none
// Frame-difference encoder. Pixel transactions (command 0) fill one half of a
// ping-pong frame store while the other half is compared, marking 64x64 tiles
// dirty; pull transactions (command 1) return the payload one byte each.
// A pixel reads the old frame, then writes the new one and marks its tile. A
// pull on the low byte of a pixel first reads the frame store. After a
// frame's last pixel and after the last byte of a tile, the next dirty tile
// is searched in the dirty map, tile by tile, and the tile found is loaded.
// After reset and after each payload's final byte, the dirty map is cleared,
// one entry per cycle, while no transaction is taken (configuration writes
// still are). Frame size is sampled at a frame's first pixel; the input format
// applies to each pixel as it arrives.
module dirty_tile_rgb565_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_command,
  input  wire logic [31:0]                     in_pixel_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_payload_byte,
  output logic                                 out_last_byte,
  output logic                                 out_whole_frame,
  output logic [dtre_pkg::COUNT_W-1:0]         out_dirty_count,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dtre_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import dtre_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PIX    = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SCHK   = 4'd5;
  localparam logic [3:0] S_GEOM   = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_RECT = 2'd2;
  localparam logic [1:0] PH_PIX  = 2'd3;

  localparam logic [3:0] HEAD_LAST = 4'd11;

  logic [3:0]         state_r;
  dim_t               cfg_w_r, cfg_h_r;
  logic               cfg_fmt_r;
  dim_t               cur_w_r, cur_h_r, prev_w_r, prev_h_r;
  logic               cur_full_r, prev_valid_r, sel_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [ADDR_W-1:0]  pix_addr_r, emit_addr_r, row_addr_r;
  logic [PIX_W-1:0]   px_r;
  logic [TIDX_W-1:0]  pix_tile_r, clr_idx_r;
  logic [COUNT_W-1:0] tally_r, scan_r;
  logic [TC_W-1:0]    tcol_r;
  logic [TR_W-1:0]    trow_r;
  logic [1:0]         phase_r;
  logic [3:0]         hpos_r;
  logic [2:0]         rpos_r;
  logic               odd_r, scan_emit_r, clr_pend_r;
  logic [TILE_SHIFT-1:0] cx_r, cy_r;
  logic [TSZ_W-1:0]   w_r, h_r;
  logic [7:0]         hi_r, res_byte_r;
  logic               res_last_r;

  // ---- configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, cfg_w_r};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, cfg_h_r};
      REG_FORMAT: prdata = {31'd0, cfg_fmt_r};
      default:    prdata = 32'd0;
    endcase
  end

  // ---- frame geometry
  logic              at_start, same;
  dim_t              w_eff, tx_full, ty_full, tx_eff_full;
  logic [TX_W-1:0]   tx, tx_eff;
  logic [TY_W-1:0]   ty;
  logic [COUNT_W-1:0] n_tiles;
  logic [TIDX_W-1:0] pix_tile;
  logic [PIX_W-1:0]  px_in;

  assign at_start    = (col_r == '0) && (row_r == '0);
  assign w_eff       = at_start ? sat_dim(cfg_w_r, dim_t'(MAX_WIDTH)) : cur_w_r;
  assign tx_full     = (cur_w_r + dim_t'(TILE - 1)) >> TILE_SHIFT;
  assign ty_full     = (cur_h_r + dim_t'(TILE - 1)) >> TILE_SHIFT;
  assign tx_eff_full = (w_eff + dim_t'(TILE - 1)) >> TILE_SHIFT;
  assign tx          = tx_full[TX_W-1:0];
  assign ty          = ty_full[TY_W-1:0];
  assign tx_eff      = tx_eff_full[TX_W-1:0];
  assign n_tiles     = COUNT_W'(tx) * COUNT_W'(ty);
  assign pix_tile    = TIDX_W'((row_r >> TILE_SHIFT) * tx_eff + (col_r >> TILE_SHIFT));
  assign same        = prev_valid_r && (prev_w_r == cur_w_r) && (prev_h_r == cur_h_r);
  assign px_in       = (cfg_fmt_r == FMT_RGB565) ? in_pixel_data[15:0]
                     : {in_pixel_data[23:19], in_pixel_data[15:10], in_pixel_data[7:3]};

  // current tile origin and clipped size
  dim_t x0, y0, w_rem, h_rem;
  logic [TSZ_W-1:0] w_geo, h_geo;
  assign x0    = dim_t'(tcol_r) << TILE_SHIFT;
  assign y0    = dim_t'(trow_r) << TILE_SHIFT;
  assign w_rem = cur_w_r - x0;
  assign h_rem = cur_h_r - y0;
  assign w_geo = (w_rem < dim_t'(TILE)) ? w_rem[TSZ_W-1:0] : TSZ_W'(TILE);
  assign h_geo = (h_rem < dim_t'(TILE)) ? h_rem[TSZ_W-1:0] : TSZ_W'(TILE);

  // ---- memories
  logic accept, rd_now, wr_now;
  logic [PIX_W-1:0] a_rdata, b_rdata, old_rdata, now_rdata;
  logic [ADDR_W-1:0] a_addr, b_addr;
  logic dm_we, dm_wdata, dm_rdata, dm_set;
  logic [TIDX_W-1:0] dm_addr;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign rd_now   = accept && (in_command == CMD_PULL) && (phase_r == PH_PIX) && !odd_r;
  assign wr_now   = (state_r == S_PIX);

  assign a_addr    = (!sel_r && rd_now) ? emit_addr_r : pix_addr_r;
  assign b_addr    = (sel_r && rd_now) ? emit_addr_r : pix_addr_r;
  assign old_rdata = sel_r ? a_rdata : b_rdata;
  assign now_rdata = sel_r ? b_rdata : a_rdata;

  dtre_ram #(.WIDTH(PIX_W), .DEPTH(STORE_N)) u_store_a (
    .clk  (clk),
    .we   (wr_now && !sel_r),
    .addr (a_addr),
    .wdata(px_r),
    .rdata(a_rdata)
  );

  dtre_ram #(.WIDTH(PIX_W), .DEPTH(STORE_N)) u_store_b (
    .clk  (clk),
    .we   (wr_now && sel_r),
    .addr (b_addr),
    .wdata(px_r),
    .rdata(b_rdata)
  );

  assign dm_set = same && (old_rdata != px_r) && !dm_rdata;

  always_comb begin
    case (state_r)
      S_CLEAR: dm_addr = clr_idx_r;
      S_PIX:   dm_addr = pix_tile_r;
      S_SCAN:  dm_addr = scan_r[TIDX_W-1:0];
      default: dm_addr = pix_tile;
    endcase
  end
  assign dm_we    = (state_r == S_CLEAR) || (wr_now && dm_set);
  assign dm_wdata = (state_r != S_CLEAR);

  dtre_ram #(.WIDTH(1), .DEPTH(GRID_N)) u_dirty_map (
    .clk  (clk),
    .we   (dm_we),
    .addr (dm_addr),
    .wdata(dm_wdata),
    .rdata(dm_rdata)
  );

  // ---- payload bytes
  logic [7:0]  hdr_byte, rec_byte;
  logic [15:0] rec_field;

  always_comb begin
    case (hpos_r)
      4'd0:    hdr_byte = 8'h46;     // F
      4'd1:    hdr_byte = 8'h44;     // D
      4'd2:    hdr_byte = 8'h52;     // R
      4'd3:    hdr_byte = 8'h31;     // 1
      4'd4:    hdr_byte = 8'(TILE & 255);
      4'd5:    hdr_byte = 8'((TILE >> 8) & 255);
      4'd6:    hdr_byte = {7'd0, cur_full_r};
      4'd8:    hdr_byte = tally_r[7:0];
      4'd9:    hdr_byte = 8'(tally_r >> 8);
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (rpos_r[2:1])
      2'd0:    rec_field = 16'(x0);
      2'd1:    rec_field = 16'(y0);
      2'd2:    rec_field = 16'(w_r);
      default: rec_field = 16'(h_r);
    endcase
    rec_byte = rpos_r[0] ? rec_field[15:8] : rec_field[7:0];
  end

  logic tcol_wrap;
  assign tcol_wrap = (TX_W'(tcol_r) + TX_W'(1)) == tx;

  // ---- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      clr_pend_r   <= 1'b0;
      cfg_w_r      <= RESET_WIDTH;
      cfg_h_r      <= RESET_HEIGHT;
      cfg_fmt_r    <= FMT_BGRA32;
      cur_w_r      <= dim_t'(1);
      cur_h_r      <= dim_t'(1);
      cur_full_r   <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_w_r     <= '0;
      prev_h_r     <= '0;
      sel_r        <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      pix_addr_r   <= '0;
      tally_r      <= '0;
      phase_r      <= PH_IDLE;
      hpos_r       <= '0;
      rpos_r       <= '0;
      odd_r        <= 1'b0;
      scan_r       <= '0;
      tcol_r       <= '0;
      trow_r       <= '0;
      scan_emit_r  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:  cfg_w_r   <= pwdata[DIM_W-1:0];
          REG_HEIGHT: cfg_h_r   <= pwdata[DIM_W-1:0];
          REG_FORMAT: cfg_fmt_r <= pwdata[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + TIDX_W'(1);
          if (clr_idx_r == TIDX_W'(GRID_N - 1)) begin
            clr_idx_r  <= '0;
            clr_pend_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            if (in_command == CMD_PIXEL) begin
              if (phase_r == PH_IDLE) begin
                if (at_start) begin
                  cur_w_r <= w_eff;
                  cur_h_r <= sat_dim(cfg_h_r, dim_t'(MAX_HEIGHT));
                  tally_r <= '0;
                end
                px_r       <= px_in;
                pix_tile_r <= pix_tile;
                state_r    <= S_PIX;
              end
            end else begin
              res_last_r <= 1'b0;
              case (phase_r)
                PH_HEAD: begin
                  res_byte_r <= hdr_byte;
                  hpos_r     <= hpos_r + 4'd1;
                  state_r    <= S_PUSH;
                  if (hpos_r == HEAD_LAST) begin
                    hpos_r <= '0;
                    if (scan_r < n_tiles) begin
                      phase_r <= PH_RECT;
                      rpos_r  <= '0;
                    end else begin
                      res_last_r <= 1'b1;
                      phase_r    <= PH_IDLE;
                      sel_r      <= ~sel_r;
                      clr_pend_r <= 1'b1;
                    end
                  end
                end
                PH_RECT: begin
                  res_byte_r <= rec_byte;
                  rpos_r     <= rpos_r + 3'd1;
                  state_r    <= S_PUSH;
                  if (rpos_r == 3'd7) begin
                    phase_r     <= PH_PIX;
                    cx_r        <= '0;
                    cy_r        <= '0;
                    odd_r       <= 1'b0;
                    emit_addr_r <= row_addr_r;
                  end
                end
                PH_PIX: begin
                  if (!odd_r) begin
                    state_r <= S_RDWAIT;
                  end else begin
                    res_byte_r <= hi_r;
                    odd_r      <= 1'b0;
                    state_r    <= S_PUSH;
                    if (TSZ_W'(cx_r) + TSZ_W'(1) == w_r) begin
                      cx_r <= '0;
                      if (TSZ_W'(cy_r) + TSZ_W'(1) == h_r) begin
                        // tile done: look for the next dirty one
                        scan_r      <= scan_r + COUNT_W'(1);
                        scan_emit_r <= 1'b1;
                        state_r     <= S_SCAN;
                        if (tcol_wrap) begin
                          tcol_r <= '0;
                          trow_r <= trow_r + TR_W'(1);
                        end else begin
                          tcol_r <= tcol_r + TC_W'(1);
                        end
                      end else begin
                        cy_r        <= cy_r + TILE_SHIFT'(1);
                        row_addr_r  <= row_addr_r + ADDR_W'(cur_w_r);
                        emit_addr_r <= row_addr_r + ADDR_W'(cur_w_r);
                      end
                    end else begin
                      cx_r        <= cx_r + TILE_SHIFT'(1);
                      emit_addr_r <= emit_addr_r + ADDR_W'(1);
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end

        S_PIX: begin
          if (dm_set) begin
            tally_r <= tally_r + COUNT_W'(1);
          end
          state_r <= S_IDLE;
          if (COL_W'(col_r + COL_W'(1)) == '0
              || dim_t'(col_r) + dim_t'(1) >= cur_w_r) begin
            col_r <= '0;
            if (dim_t'(row_r) + dim_t'(1) >= cur_h_r) begin
              // frame closes
              row_r        <= '0;
              pix_addr_r   <= '0;
              cur_full_r   <= !same;
              if (!same) begin
                tally_r <= n_tiles;
              end
              prev_valid_r <= 1'b1;
              prev_w_r     <= cur_w_r;
              prev_h_r     <= cur_h_r;
              phase_r      <= PH_HEAD;
              hpos_r       <= '0;
              scan_r       <= '0;
              tcol_r       <= '0;
              trow_r       <= '0;
              scan_emit_r  <= 1'b0;
              state_r      <= S_SCAN;
            end else begin
              row_r      <= row_r + ROW_W'(1);
              pix_addr_r <= pix_addr_r + ADDR_W'(1);
            end
          end else begin
            col_r      <= col_r + COL_W'(1);
            pix_addr_r <= pix_addr_r + ADDR_W'(1);
          end
        end

        S_RDWAIT: begin
          res_byte_r <= now_rdata[7:0];
          hi_r       <= now_rdata[15:8];
          odd_r      <= 1'b1;
          state_r    <= S_PUSH;
        end

        S_SCAN: begin
          if (scan_r >= n_tiles) begin
            if (scan_emit_r) begin
              res_last_r <= 1'b1;
              phase_r    <= PH_IDLE;
              sel_r      <= ~sel_r;
              clr_pend_r <= 1'b1;
              state_r    <= S_PUSH;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (cur_full_r) begin
            state_r <= S_GEOM;
          end else begin
            state_r <= S_SCHK;
          end
        end

        S_SCHK: begin
          if (dm_rdata) begin
            state_r <= S_GEOM;
          end else begin
            scan_r  <= scan_r + COUNT_W'(1);
            state_r <= S_SCAN;
            if (tcol_wrap) begin
              tcol_r <= '0;
              trow_r <= trow_r + TR_W'(1);
            end else begin
              tcol_r <= tcol_r + TC_W'(1);
            end
          end
        end

        S_GEOM: begin
          w_r        <= w_geo;
          h_r        <= h_geo;
          row_addr_r <= ADDR_W'(y0) * ADDR_W'(cur_w_r) + ADDR_W'(x0);
          if (scan_emit_r) begin
            phase_r <= PH_RECT;
            rpos_r  <= '0;
            state_r <= S_PUSH;
          end else begin
            state_r <= S_IDLE;
          end
        end

        S_PUSH: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            out_payload_byte <= res_byte_r;
            out_last_byte    <= res_last_r;
            out_whole_frame  <= cur_full_r;
            out_dirty_count  <= tally_r;
            state_r          <= clr_pend_r ? S_CLEAR : S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
